FILE: rtl/core/sls_pkg.sv
// Shared types, sizes and codes for the sortable LIFO stack.
package sls_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_SORT = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] push_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic               top_valid;
    logic [4:0]         count;
  } out_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOPRD,
    S_RESP,
    S_SORT_RD0,
    S_SORT_LOAD,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_LAST
  } ctrl_state_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       latch_status;
    logic [1:0] status;
    logic       rd_top;
    logic       rd_idx;
    logic       sort_init;
    logic       load_carry;
    logic       cmp_step;
    logic       write_last;
    logic       respond;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic cnt_small;
    logic idx_at_end;
    logic end_at_one;
  } dp_stat_t;

endpackage

FILE: rtl/core/sls_ctrl.sv
// Controller state machine that sequences requests and the sort passes.
module sls_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         action,
  input  sls_pkg::dp_stat_t  stat,
  output logic               busy,
  output sls_pkg::dp_cmd_t   cmd
);

  sls_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sls_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.status = sls_pkg::ST_DONE;
    busy       = (state_r != sls_pkg::S_IDLE);
    case (state_r)
      sls_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch_status = 1'b1;
          state_nxt        = sls_pkg::S_TOPRD;
          case (action)
            sls_pkg::ACT_PUSH: begin
              if (stat.cnt_full) begin
                cmd.status = sls_pkg::ST_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            sls_pkg::ACT_POP: begin
              if (stat.cnt_zero) begin
                cmd.status = sls_pkg::ST_EMPTY;
              end else begin
                cmd.pop = 1'b1;
              end
            end
            sls_pkg::ACT_SORT: begin
              if (!stat.cnt_small) begin
                cmd.sort_init = 1'b1;
                state_nxt     = sls_pkg::S_SORT_RD0;
              end
            end
            default: begin
              cmd.status = sls_pkg::ST_DONE;
            end
          endcase
        end
      end
      sls_pkg::S_TOPRD: begin
        cmd.rd_top = 1'b1;
        state_nxt  = sls_pkg::S_RESP;
      end
      sls_pkg::S_RESP: begin
        cmd.respond = 1'b1;
        state_nxt   = sls_pkg::S_IDLE;
      end
      sls_pkg::S_SORT_RD0: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = sls_pkg::S_SORT_LOAD;
      end
      sls_pkg::S_SORT_LOAD: begin
        cmd.load_carry = 1'b1;
        state_nxt      = sls_pkg::S_SORT_RD;
      end
      sls_pkg::S_SORT_RD: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = sls_pkg::S_SORT_CMP;
      end
      sls_pkg::S_SORT_CMP: begin
        cmd.cmp_step = 1'b1;
        state_nxt    = stat.idx_at_end ? sls_pkg::S_SORT_LAST : sls_pkg::S_SORT_RD;
      end
      sls_pkg::S_SORT_LAST: begin
        cmd.write_last = 1'b1;
        state_nxt      = stat.end_at_one ? sls_pkg::S_TOPRD : sls_pkg::S_SORT_RD0;
      end
      default: begin
        state_nxt = sls_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/sls_dp.sv
// Datapath: entry memory, count, sort carry register and result registers.
module sls_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sls_pkg::in_req_t   req,
  input  sls_pkg::dp_cmd_t   cmd,
  output sls_pkg::dp_stat_t  stat,
  output logic               out_strobe,
  output sls_pkg::out_rsp_t  out_rsp
);

  logic signed [31:0] mem [sls_pkg::DEPTH];

  logic [sls_pkg::CW-1:0] count_r, count_nxt;
  logic [sls_pkg::AW-1:0] idx_r, idx_nxt;
  logic [sls_pkg::AW-1:0] end_r, end_nxt;
  logic signed [31:0]     carry_r, carry_nxt;
  logic signed [31:0]     rdata_r;
  logic [1:0]             status_r, status_nxt;
  logic                   strobe_r, strobe_nxt;
  sls_pkg::out_rsp_t      rsp_r, rsp_nxt;

  logic                   wr_en;
  logic [sls_pkg::AW-1:0] wr_addr;
  logic signed [31:0]     wr_data;
  logic [sls_pkg::AW-1:0] rd_addr;

  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    end_nxt    = end_r;
    carry_nxt  = carry_r;
    status_nxt = status_r;
    strobe_nxt = cmd.respond;
    rsp_nxt    = rsp_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = carry_r;
    rd_addr    = idx_r;

    if (cmd.latch_status) begin
      status_nxt = cmd.status;
    end
    if (cmd.push) begin
      wr_en     = 1'b1;
      wr_addr   = sls_pkg::AW'(count_r);
      wr_data   = req.push_value;
      count_nxt = count_r + 1'b1;
    end
    if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
    if (cmd.sort_init) begin
      idx_nxt = '0;
      end_nxt = sls_pkg::AW'(count_r - 1'b1);
    end
    if (cmd.rd_idx) begin
      rd_addr = idx_r;
    end
    if (cmd.rd_top) begin
      rd_addr = sls_pkg::AW'(count_r - 1'b1);
    end
    if (cmd.load_carry) begin
      carry_nxt = rdata_r;
      idx_nxt   = idx_r + 1'b1;
    end
    if (cmd.cmp_step) begin
      // The larger value settles one place down; the smaller rides upward.
      wr_en   = 1'b1;
      wr_addr = idx_r - 1'b1;
      if (carry_r < rdata_r) begin
        wr_data = rdata_r;
      end else begin
        wr_data   = carry_r;
        carry_nxt = rdata_r;
      end
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.write_last) begin
      wr_en   = 1'b1;
      wr_addr = end_r;
      wr_data = carry_r;
      end_nxt = end_r - 1'b1;
      idx_nxt = '0;
    end
    if (cmd.respond) begin
      rsp_nxt.status    = status_r;
      rsp_nxt.top_valid = (count_r != '0);
      rsp_nxt.top_value = (count_r != '0) ? rdata_r : 32'sd0;
      rsp_nxt.count     = 5'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    end_r    <= end_nxt;
    carry_r  <= carry_nxt;
    status_r <= status_nxt;
    rsp_r    <= rsp_nxt;
  end

  always_comb begin
    stat.cnt_zero   = (count_r == '0);
    stat.cnt_full   = (count_r == sls_pkg::CW'(sls_pkg::DEPTH));
    stat.cnt_small  = (count_r < sls_pkg::CW'(2));
    stat.idx_at_end = (idx_r == end_r);
    stat.end_at_one = (end_r == sls_pkg::AW'(1));
  end

  assign out_strobe = strobe_r;
  assign out_rsp    = rsp_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sls_pkg::CW'(sls_pkg::DEPTH))
    else $error("entry count exceeds depth");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("result strobe held for two cycles");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !stat.cnt_full)
    else $error("push issued on a full stack");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stat.cnt_zero)
    else $error("pop issued on an empty stack");
`endif

endmodule

FILE: rtl/core/sortable_lifo_stack_unit.sv
// Top level of the sortable LIFO stack: controller plus datapath.
//
//  Channel   Ports                      Direction  Handshake
//  request   start, busy, in_req        in         accepted when start && !busy
//  result    out_strobe, out_rsp        out        one-cycle strobe, no backpressure
//
// For push, pop and unused action codes the controller steps through S_TOPRD and
// S_RESP and then registers the result strobe, and a new request is accepted at the
// edge that ends the strobe cycle; the single read port of the entry memory with its
// registered read data sets this sequence. A sort of n entries (n >= 2) runs
// bubble passes over that read port before the top is read.
// busy stays high through all of this. rst_n is synchronous and active low:
// it empties the stack; the entry memory itself is not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
module sortable_lifo_stack_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sls_pkg::in_req_t   in_req,
  output logic               out_strobe,
  output sls_pkg::out_rsp_t  out_rsp
);

  // Command and status groups between the controller and the datapath.
  sls_pkg::dp_cmd_t  cmd;
  sls_pkg::dp_stat_t stat;

  // The controller decides what each cycle does; it sees only start, the action code and status flags.
  sls_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_req.action),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  // The datapath holds the entries, the count and the result registers.
  sls_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_req),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

endmodule

FILE: bench/tb_sortable_lifo_stack_unit.sv
// Self-checking testbench for the sortable LIFO stack: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_sortable_lifo_stack_unit;

  // Action code 3 has no meaning; the block must report its state and change nothing.
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam int RAND_ITEMS  = 1400;
  localparam int DRAIN_WAIT  = 12;
  localparam int CYCLE_LIMIT = 2_000_000;

  // One row of the directed table. A row may repeat its request, and may carry a
  // response that is typed in by hand instead of taken from the predictor.
  typedef struct packed {
    sls_pkg::in_req_t  req;
    logic [4:0]        reps;
    logic              fixed;
    sls_pkg::out_rsp_t rsp;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  sls_pkg::in_req_t  in_req = '0;
  logic              out_strobe;
  sls_pkg::out_rsp_t out_rsp;

  // Hand-typed response for the request currently offered, if the table has one.
  logic              cur_fixed = 1'b0;
  sls_pkg::out_rsp_t cur_fixed_rsp = '0;

  // Shadow copy of the stack: index 0 is the bottom, shadow_cnt-1 the top.
  logic signed [31:0] shadow_mem [sls_pkg::DEPTH];
  int                 shadow_cnt = 0;

  sls_pkg::out_rsp_t stack_reply_q [$];
  stim_row_t         dir_tab [$];
  int                err_cnt = 0;
  int                cycle_cnt = 0;

  sortable_lifo_stack_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic sls_pkg::out_rsp_t mk_rsp(input logic [1:0] st,
                                               input logic [31:0] val,
                                               input logic vld, input logic [4:0] cnt);
    sls_pkg::out_rsp_t r;
    r.status    = st;
    r.top_value = val;
    r.top_valid = vld;
    r.count     = cnt;
    return r;
  endfunction

  // Applies one request to the shadow stack and returns the response it must give.
  function automatic sls_pkg::out_rsp_t apply_stack_op(input sls_pkg::in_req_t req);
    sls_pkg::out_rsp_t  r;
    logic signed [31:0] v;
    int                 k;
    r = '0;
    r.status = sls_pkg::ST_DONE;
    case (req.action)
      sls_pkg::ACT_PUSH: begin
        if (shadow_cnt >= sls_pkg::DEPTH) begin
          r.status = sls_pkg::ST_FULL;
        end else begin
          shadow_mem[shadow_cnt] = req.push_value;
          shadow_cnt++;
        end
      end
      sls_pkg::ACT_POP: begin
        if (shadow_cnt == 0) r.status = sls_pkg::ST_EMPTY;
        else shadow_cnt--;
      end
      sls_pkg::ACT_SORT: begin
        // Insertion sort, largest at the bottom so that the smallest ends on top.
        for (int i = 1; i < shadow_cnt; i++) begin
          v = shadow_mem[i];
          k = i;
          while (k > 0 && shadow_mem[k-1] < v) begin
            shadow_mem[k] = shadow_mem[k-1];
            k--;
          end
          shadow_mem[k] = v;
        end
      end
      default: begin
      end
    endcase
    if (shadow_cnt > 0) begin
      r.top_value = shadow_mem[shadow_cnt-1];
      r.top_valid = 1'b1;
    end
    r.count = shadow_cnt[4:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    err_cnt++;
  endtask

  // Offers one request after an idle gap and returns at the falling edge after
  // it was taken. Entered and left at a falling edge.
  task automatic send_request(input sls_pkg::in_req_t req, input logic fixed,
                              input sls_pkg::out_rsp_t rsp, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_req        <= req;
    cur_fixed     <= fixed;
    cur_fixed_rsp <= rsp;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Lowers start and holds off until every outstanding response has come back.
  task automatic wait_all_replies();
    start <= 1'b0;
    do @(negedge clk); while (stack_reply_q.size() != 0);
  endtask

  task automatic add_row(input logic [1:0] act, input logic [31:0] val, input int reps,
                         input logic fixed, input sls_pkg::out_rsp_t rsp);
    stim_row_t row;
    row.req.action     = act;
    row.req.push_value = val;
    row.reps           = reps[4:0];
    row.fixed          = fixed;
    row.rsp            = rsp;
    dir_tab.push_back(row);
  endtask

  // Response checking and prediction, both on the rising edge. A response leaving
  // the block is checked before a request taken at the same edge is predicted.
  always @(posedge clk) begin : mon_blk
    sls_pkg::out_rsp_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (stack_reply_q.size() == 0) begin
          $display("%0t: response with none outstanding, expected nothing, actual %0h",
                   $time, out_rsp);
          err_cnt++;
        end else begin
          want = stack_reply_q.pop_front();
          if (out_rsp.status !== want.status)
            report_field("status", 32'(want.status), 32'(out_rsp.status));
          if (out_rsp.top_value !== want.top_value)
            report_field("top_value", want.top_value, out_rsp.top_value);
          if (out_rsp.top_valid !== want.top_valid)
            report_field("top_valid", 32'(want.top_valid), 32'(out_rsp.top_valid));
          if (out_rsp.count !== want.count)
            report_field("count", 32'(want.count), 32'(out_rsp.count));
        end
      end
      if (start && !busy) begin
        want = apply_stack_op(in_req);
        // A typed response still lets the shadow stack advance.
        if (cur_fixed) want = cur_fixed_rsp;
        stack_reply_q.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stim_blk
    sls_pkg::in_req_t req;
    int               gap;
    int               pick;
    int               done_items;
    logic             draining;
    logic             burst;

    // Directed part: an empty stack first, then the extremes of the value range,
    // a sort of a single entry, a mixed sort, and a push against a full stack.
    add_row(sls_pkg::ACT_POP,  32'h0, 1, 1'b1,
            mk_rsp(sls_pkg::ST_EMPTY, 32'h0, 1'b0, 5'd0));
    add_row(sls_pkg::ACT_SORT, 32'h0, 1, 1'b1,
            mk_rsp(sls_pkg::ST_DONE, 32'h0, 1'b0, 5'd0));
    add_row(ACT_NONE, 32'hFFFF_FFFF, 1, 1'b1,
            mk_rsp(sls_pkg::ST_DONE, 32'h0, 1'b0, 5'd0));
    add_row(sls_pkg::ACT_PUSH, 32'h7FFF_FFFF, 1, 1'b1,
            mk_rsp(sls_pkg::ST_DONE, 32'h7FFF_FFFF, 1'b1, 5'd1));
    add_row(sls_pkg::ACT_SORT, 32'h0, 1, 1'b1,
            mk_rsp(sls_pkg::ST_DONE, 32'h7FFF_FFFF, 1'b1, 5'd1));
    add_row(sls_pkg::ACT_PUSH, 32'h8000_0000, 1, 1'b1,
            mk_rsp(sls_pkg::ST_DONE, 32'h8000_0000, 1'b1, 5'd2));
    add_row(sls_pkg::ACT_PUSH, 32'h0, 1, 1'b0, '0);
    add_row(sls_pkg::ACT_PUSH, 32'hFFFF_FFFF, 1, 1'b0, '0);
    add_row(sls_pkg::ACT_SORT, 32'h0, 1, 1'b0, '0);
    add_row(ACT_NONE, 32'h1234_5678, 1, 1'b0, '0);
    add_row(sls_pkg::ACT_POP,  32'h0, 1, 1'b0, '0);
    add_row(sls_pkg::ACT_PUSH, 32'h5A5A_5A5A, 12, 1'b0, '0);
    add_row(sls_pkg::ACT_PUSH, 32'h8000_0001, 1, 1'b0, '0);
    add_row(sls_pkg::ACT_PUSH, 32'h0000_0001, 1, 1'b1,
            mk_rsp(sls_pkg::ST_FULL, 32'h8000_0001, 1'b1, 5'd16));
    add_row(sls_pkg::ACT_SORT, 32'h0, 1, 1'b0, '0);
    add_row(sls_pkg::ACT_POP,  32'h0, 1, 1'b0, '0);

    // Synchronous reset held low first, then released at a falling edge.
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      repeat (dir_tab[i].reps) begin
        send_request(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].rsp,
                     $urandom_range(0, 16));
      end
    end

    // Random part. The mix swings between filling and draining so that both the
    // full and the empty stack are reached often, with sorts at every depth.
    done_items = 0;
    draining   = 1'b0;
    burst      = 1'b0;
    while (done_items < RAND_ITEMS) begin
      if (done_items % 50 == 0) burst = ($urandom_range(0, 2) == 0);
      if (shadow_cnt == sls_pkg::DEPTH) draining = 1'b1;
      else if (shadow_cnt == 0) draining = 1'b0;
      else if ($urandom_range(0, 39) == 0) draining = !draining;

      pick = $urandom_range(0, 99);
      req.push_value = rand_value();
      if (pick < 4) req.action = ACT_NONE;
      else if (pick < 20) req.action = sls_pkg::ACT_SORT;
      else if (pick < (draining ? 35 : 75)) req.action = sls_pkg::ACT_PUSH;
      else req.action = sls_pkg::ACT_POP;

      // Now and then let the block run completely dry before the next request.
      if (done_items == RAND_ITEMS / 2 || $urandom_range(0, 63) == 0) wait_all_replies();

      gap = burst ? 0 : $urandom_range(0, 16);
      send_request(req, 1'b0, '0, gap);
      if (req.action != ACT_NONE) done_items++;
    end

    wait_all_replies();
    repeat (DRAIN_WAIT) @(negedge clk);

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
